// ===== hw/rtl/ppsu_pkg.sv =====
// Shared types, constants and helpers for the partition point selector.
package ppsu_pkg;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = 3;
  localparam int DATA_W    = 24;
  localparam int COUNT_W   = 10;
  localparam int USAGE_W   = 13;
  localparam int DIV_STEPS = DATA_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int QUAL_W    = DATA_W + 5;
  localparam int RANK_W    = DATA_W + SLOT_W;

  localparam logic [COUNT_W-1:0] MAX_COUNT = {COUNT_W{1'b1}};

  // configuration register indexes
  localparam logic REG_REQUEST_RATE = 1'b0;
  localparam logic REG_SLO_LATENCY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_SAT,
    S_MUL,
    S_REM,
    S_TAIL,
    S_DONE
  } state_t;

  // best point overall
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] metric;
  } best_status_t;

  // best point of the slot being read
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] tp;
  } slot_status_t;

  // slot 0..3 -> size 1..4, slot 4 -> size 7
  function automatic logic [SLOT_W-1:0] slot_size(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] size;
    case (slot)
      3'd0:    size = 3'd1;
      3'd1:    size = 3'd2;
      3'd2:    size = 3'd3;
      3'd3:    size = 3'd4;
      3'd4:    size = 3'd7;
      default: size = 3'd0;
    endcase
    return size;
  endfunction

endpackage

// ===== hw/rtl/partition_point_selector_unit.sv =====
// Partition point selector: top level with sequencer and shared subtractor.
//
// Each profiled point is registered on its transfer and then qualified in the
// evaluate state, which updates the best points. On the point marked last the
// evaluate state is followed by the divide, saturate, multiply, remainder, tail
// and done states, the last repeated while an unread result holds the output
// register: the instance count comes from a restoring divider that retires one
// quotient bit per cycle on the shared 25-bit subtractor, which then forms the
// remaining rate and scans the five size slots one per cycle for the tail
// instance. in_ready is high only between points; a finished result sits in the
// output register, so the next model's points can stream in while it waits.
module partition_point_selector_unit
  import ppsu_pkg::*;
#(
  parameter int BATCH_SLOTS = 16,
  parameter int PROC_SLOTS  = 8,
  localparam int BW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1,
  localparam int PW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [DATA_W-1:0]  cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SLOT_W-1:0]  size_slot,
  input  logic [BW-1:0]      batch_index,
  input  logic [PW-1:0]      proc_index,
  input  logic [DATA_W-1:0]  throughput,
  input  logic [DATA_W-1:0]  latency,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               found,
  output logic [SLOT_W-1:0]  best_size,
  output logic [BW-1:0]      best_batch,
  output logic [PW-1:0]      best_proc,
  output logic [COUNT_W-1:0] instance_count,
  output logic               tail_fits,
  output logic [SLOT_W-1:0]  tail_size,
  output logic [BW-1:0]      tail_batch,
  output logic [PW-1:0]      tail_proc,
  output logic [USAGE_W-1:0] total_usage
);

  state_t state, state_next;

  logic [DATA_W-1:0] request_rate;
  logic [DATA_W-1:0] slo_latency;

  logic [SLOT_W-1:0] pt_slot;
  logic [BW-1:0]     pt_batch;
  logic [PW-1:0]     pt_proc;
  logic [DATA_W-1:0] pt_trp;
  logic [DATA_W-1:0] pt_ltc;
  logic              pt_last;

  logic [DATA_W-1:0] div_rem;
  logic [DATA_W-1:0] div_work;
  logic [STEP_W-1:0] div_step;
  logic [COUNT_W-1:0] count;
  logic [DATA_W-1:0] product;
  logic [DATA_W-1:0] remaining;
  logic [SLOT_W-1:0] scan_idx;
  logic              tail_hit;
  logic [SLOT_W-1:0] tail_slot;
  logic [BW-1:0]     tail_batch_r;
  logic [PW-1:0]     tail_proc_r;

  logic              in_xfer;
  logic              upd;
  logic              clr;
  logic              load_out;
  logic              div_last;
  logic              tail_fit;
  logic              scan_end;
  logic [SLOT_W-1:0] rd_slot;

  best_status_t      best;
  logic [BW-1:0]     trk_best_batch;
  logic [PW-1:0]     trk_best_proc;
  slot_status_t      slot_st;
  logic [BW-1:0]     slot_batch_rd;
  logic [PW-1:0]     slot_proc_rd;

  logic [DATA_W:0]   sub_a;
  logic [DATA_W:0]   sub_b;
  logic [DATA_W:0]   sub_diff;
  logic              sub_borrow;

  logic [DATA_W+COUNT_W-1:0] mul_full;
  logic [SLOT_W-1:0]  bsize;
  logic [SLOT_W-1:0]  tsize;
  logic [COUNT_W-1:0] count_out;
  logic               tail_ok;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      request_rate <= '0;
      slo_latency  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REQUEST_RATE: request_rate <= cfg_data;
        REG_SLO_LATENCY:  slo_latency  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pt_slot  <= size_slot;
      pt_batch <= batch_index;
      pt_proc  <= proc_index;
      pt_trp   <= throughput;
      pt_ltc   <= latency;
      pt_last  <= last_point;
    end
  end

  assign rd_slot = (state == S_TAIL) ? scan_idx : pt_slot;

  ppsu_tracker #(
    .BATCH_SLOTS (BATCH_SLOTS),
    .PROC_SLOTS  (PROC_SLOTS)
  ) u_tracker (
    .clk           (clk),
    .rst           (rst),
    .upd           (upd),
    .clr           (clr),
    .slo_latency   (slo_latency),
    .rd_slot       (rd_slot),
    .pt_batch      (pt_batch),
    .pt_proc       (pt_proc),
    .pt_trp        (pt_trp),
    .pt_ltc        (pt_ltc),
    .best          (best),
    .best_batch    (trk_best_batch),
    .best_proc     (trk_best_proc),
    .slot_st       (slot_st),
    .slot_batch_rd (slot_batch_rd),
    .slot_proc_rd  (slot_proc_rd)
  );

  // shared subtractor: divider step, remaining rate, tail compare
  always_comb begin
    case (state)
      S_DIV: begin
        sub_a = {div_rem, div_work[DATA_W-1]};
        sub_b = {1'b0, best.metric};
      end
      S_REM: begin
        sub_a = {1'b0, request_rate};
        sub_b = {1'b0, product};
      end
      S_TAIL: begin
        sub_a = {1'b0, slot_st.tp};
        sub_b = {1'b0, remaining};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  assign div_last = (32'(div_step) == DIV_STEPS - 1);
  assign tail_fit = slot_st.valid && !sub_borrow;
  assign scan_end = (32'(scan_idx) == NUM_SLOTS - 1);
  assign mul_full = (DATA_W+COUNT_W)'(best.metric) * (DATA_W+COUNT_W)'(count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_xfer) state_next = S_EVAL;
      S_EVAL: state_next = pt_last ? S_DIV : S_IDLE;
      S_DIV:  if (div_last) state_next = S_SAT;
      S_SAT:  state_next = S_MUL;
      S_MUL:  state_next = S_REM;
      S_REM:  state_next = S_TAIL;
      S_TAIL: if (tail_fit || scan_end) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    in_ready = 1'b0;
    upd      = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_EVAL: upd      = 1'b1;
      S_DONE: load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign clr = load_out;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sizing datapath
  always_ff @(posedge clk) begin
    case (state)
      S_EVAL: begin
        div_rem  <= '0;
        div_work <= request_rate - DATA_W'(1);
        div_step <= '0;
      end
      S_DIV: begin
        div_rem  <= sub_borrow ? sub_a[DATA_W-1:0] : sub_diff[DATA_W-1:0];
        div_work <= {div_work[DATA_W-2:0], !sub_borrow};
        div_step <= div_step + STEP_W'(1);
      end
      S_SAT: begin
        if (request_rate == '0)
          count <= '0;
        else if (|div_work[DATA_W-1:COUNT_W])
          count <= MAX_COUNT;
        else
          count <= div_work[COUNT_W-1:0];
      end
      S_MUL: product <= mul_full[DATA_W-1:0];
      S_REM: begin
        remaining <= sub_diff[DATA_W-1:0];
        scan_idx  <= '0;
        tail_hit  <= 1'b0;
      end
      S_TAIL: begin
        if (tail_fit) begin
          tail_hit     <= 1'b1;
          tail_slot    <= scan_idx;
          tail_batch_r <= slot_batch_rd;
          tail_proc_r  <= slot_proc_rd;
        end else if (!scan_end) begin
          scan_idx <= scan_idx + SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register
  assign tail_ok   = best.valid && tail_hit;
  assign bsize     = best.valid ? slot_size(best.slot) : '0;
  assign tsize     = tail_ok ? slot_size(tail_slot) : '0;
  assign count_out = best.valid ? count : '0;

  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (load_out)
      out_valid <= 1'b1;
    else if (out_ready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found          <= best.valid;
      best_size      <= bsize;
      best_batch     <= best.valid ? trk_best_batch : '0;
      best_proc      <= best.valid ? trk_best_proc : '0;
      instance_count <= count_out;
      tail_fits      <= tail_ok;
      tail_size      <= tsize;
      tail_batch     <= tail_ok ? tail_batch_r : '0;
      tail_proc      <= tail_ok ? tail_proc_r : '0;
      total_usage    <= USAGE_W'(bsize) * USAGE_W'(count_out) + USAGE_W'(tsize);
    end
  end

endmodule

// ===== hw/rtl/ppsu_tracker.sv =====
// Point qualification and best-point tracking, overall and per size slot.
module ppsu_tracker
  import ppsu_pkg::*;
#(
  parameter int BATCH_SLOTS = 16,
  parameter int PROC_SLOTS  = 8,
  localparam int BW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1,
  localparam int PW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              upd,
  input  logic              clr,
  input  logic [DATA_W-1:0] slo_latency,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic [BW-1:0]     pt_batch,
  input  logic [PW-1:0]     pt_proc,
  input  logic [DATA_W-1:0] pt_trp,
  input  logic [DATA_W-1:0] pt_ltc,
  output best_status_t      best,
  output logic [BW-1:0]     best_batch,
  output logic [PW-1:0]     best_proc,
  output slot_status_t      slot_st,
  output logic [BW-1:0]     slot_batch_rd,
  output logic [PW-1:0]     slot_proc_rd
);

  logic [DATA_W-1:0] slot_tp    [NUM_SLOTS];
  logic              slot_valid [NUM_SLOTS];
  logic [BW-1:0]     slot_batch [NUM_SLOTS];
  logic [PW-1:0]     slot_proc  [NUM_SLOTS];

  logic              rd_ok;
  logic              in_range;
  logic [QUAL_W-1:0] ltc_x20;
  logic [QUAL_W-1:0] slo_x9;
  logic              qualify;
  logic [RANK_W-1:0] rank_new;
  logic [RANK_W-1:0] rank_old;
  logic              better;
  logic              slot_better;

  assign rd_ok = (32'(rd_slot) < NUM_SLOTS);

  always_comb begin
    if (rd_ok) begin
      slot_st.valid = slot_valid[rd_slot];
      slot_st.tp    = slot_tp[rd_slot];
      slot_batch_rd = slot_batch[rd_slot];
      slot_proc_rd  = slot_proc[rd_slot];
    end else begin
      slot_st       = '0;
      slot_batch_rd = '0;
      slot_proc_rd  = '0;
    end
  end

  // latency below 45 percent of the slo, compared with shift-adds
  assign ltc_x20 = (QUAL_W'(pt_ltc) << 4) + (QUAL_W'(pt_ltc) << 2);
  assign slo_x9  = (QUAL_W'(slo_latency) << 3) + QUAL_W'(slo_latency);

  assign in_range = rd_ok && (32'(pt_batch) < BATCH_SLOTS) && (32'(pt_proc) < PROC_SLOTS);
  assign qualify  = in_range && (ltc_x20 < slo_x9) && (pt_trp != '0);

  // throughput per size, cross-multiplied
  assign rank_new = RANK_W'(pt_trp) * RANK_W'(slot_size(best.slot));
  assign rank_old = RANK_W'(best.metric) * RANK_W'(slot_size(rd_slot));
  assign better   = !best.valid || (rank_new > rank_old);
  assign slot_better = (pt_trp > slot_st.tp);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      best <= '0;
    end else if (upd && qualify && better) begin
      best.valid  <= 1'b1;
      best.slot   <= rd_slot;
      best.metric <= pt_trp;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && qualify && better) begin
      best_batch <= pt_batch;
      best_proc  <= pt_proc;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (rst || clr) begin
        slot_valid[i] <= 1'b0;
        slot_tp[i]    <= '0;
      end else if (upd && qualify && slot_better && (32'(rd_slot) == i)) begin
        slot_valid[i] <= 1'b1;
        slot_tp[i]    <= pt_trp;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (upd && qualify && slot_better && (32'(rd_slot) == i)) begin
        slot_batch[i] <= pt_batch;
        slot_proc[i]  <= pt_proc;
      end
    end
  end

endmodule

// ===== hw/rtl/ppsu_checker.sv =====
// Port-level assertions for the partition point selector, bound to the top level.
module ppsu_checker
  import ppsu_pkg::*;
#(
  parameter int BATCH_SLOTS = 16,
  parameter int PROC_SLOTS  = 8,
  localparam int BW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1,
  localparam int PW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               found,
  input logic [SLOT_W-1:0]  best_size,
  input logic [BW-1:0]      best_batch,
  input logic [PW-1:0]      best_proc,
  input logic [COUNT_W-1:0] instance_count,
  input logic               tail_fits,
  input logic [SLOT_W-1:0]  tail_size,
  input logic [USAGE_W-1:0] total_usage
);

  // a point transfer is always followed by a busy state with in_ready low
  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high straight after a point transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_usage) &&
      $stable(instance_count) && $stable(best_batch) && $stable(best_proc))
    else $error("stalled result changed or dropped");

  // no qualifying point gives an all-zero sizing
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> best_size == '0 && instance_count == '0 &&
      !tail_fits && total_usage == '0)
    else $error("sizing reported without a qualifying point");

  // a tail only ever follows a found point, and has a real size
  a_tail_sane: assert property (@(posedge clk) disable iff (rst)
    out_valid && tail_fits |-> found && tail_size != '0)
    else $error("tail reported without a size or a best point");

endmodule

bind partition_point_selector_unit ppsu_checker #(
  .BATCH_SLOTS (BATCH_SLOTS),
  .PROC_SLOTS  (PROC_SLOTS)
) u_ppsu_checker (.*);
